// ----- src/elur_pkg.sv -----
// shared types, codes and widths for the edit log undo/redo core
// no dependencies; imported by elur_ctrl, elur_dp and edit_log_undo_redo_core
package elur_pkg;

  localparam int ID_BITS       = 16;
  localparam int CNT_BITS      = ID_BITS + 1;
  localparam int LOG_DEPTH_DEF = 256;
  localparam int OP_BITS       = 3;
  localparam int ST_BITS       = 2;
  localparam int KIND_BITS     = 2;

  // stream beat widths, rounded up to whole bytes
  localparam int IN_RAW  = OP_BITS + ID_BITS;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = ST_BITS + ID_BITS + 1 + CNT_BITS + 1 + 1;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [OP_BITS-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DEL   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_UPD   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_UNDO  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_REDO  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_QUERY = 3'd5;

  localparam logic [ST_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [ST_BITS-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_BITS-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_BITS-1:0] ST_FULL    = 2'd3;

  localparam logic [KIND_BITS-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_DEL = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_UPD = 2'd2;

  // register addresses (byte offsets)
  localparam int                CFG_AW       = 3;
  localparam logic [CFG_AW-1:0] REG_START_ID = 3'd0;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // run an op that needs no log read
    logic start_rd;  // first log read for undo, redo or query
    logic apply_ur;  // finish undo or redo with the read kind
    logic scan_step; // query: move one entry down
    logic scan_end;  // query: write the answer
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_mem;
    logic is_query;
    logic scan_stop;
  } sts_t;

endpackage

// ----- src/elur_ctrl.sv -----
// sequencing state machine for the edit log undo/redo core
// depends on elur_pkg for the command and status structs
module elur_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  elur_pkg::sts_t sts_i,
  output elur_pkg::cmd_t cmd_o
);
  import elur_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.needs_mem) begin
          cmd_o.start_rd = 1'b1;
          state_d        = sts_i.is_query ? S_SCAN : S_READ;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_OUT;
        end
      end
      S_READ: begin
        cmd_o.apply_ur = 1'b1;
        state_d        = S_OUT;
      end
      S_SCAN: begin
        if (sts_i.scan_stop) begin
          cmd_o.scan_end = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/elur_dp.sv -----
// datapath of the edit log undo/redo core: log memory, cursor, counters, result
// depends on elur_pkg for codes, widths and the command and status structs
module elur_dp #(
  parameter int LOG_DEPTH = elur_pkg::LOG_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [elur_pkg::ID_BITS-1:0]        cfg_wdata_i,
  output logic [elur_pkg::ID_BITS-1:0]        start_id_o,
  input  logic [elur_pkg::OP_BITS-1:0]        in_op_i,
  input  logic [elur_pkg::ID_BITS-1:0]        in_id_i,
  input  elur_pkg::cmd_t                      cmd_i,
  output elur_pkg::sts_t                      sts_o,
  output logic [elur_pkg::ST_BITS-1:0]        status_o,
  output logic [elur_pkg::ID_BITS-1:0]        assigned_o,
  output logic                                exists_o,
  output logic signed [elur_pkg::CNT_BITS-1:0] valid_count_o,
  output logic                                can_undo_o,
  output logic                                can_redo_o
);
  import elur_pkg::*;

  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int EW = ID_BITS + KIND_BITS;

  logic [EW-1:0]        mem_q [LOG_DEPTH];
  logic [CW-1:0]        applied_q, applied_d, top_q, top_d;
  logic [ID_BITS:0]     next_q, next_d;
  logic [CNT_BITS-1:0]  vt_q, vt_d;
  logic [ID_BITS-1:0]   start_q, start_d;
  logic [OP_BITS-1:0]   op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [AW-1:0]        p_q, p_d;
  logic [ID_BITS-1:0]   rd_id_q;
  logic [KIND_BITS-1:0] rd_kind_q;
  logic [ST_BITS-1:0]   res_status_q, res_status_d;
  logic [ID_BITS-1:0]   res_assigned_q, res_assigned_d;
  logic                 res_exists_q, res_exists_d;

  logic                 full, id_ok, hit, push, rd_en;
  logic [ID_BITS-1:0]   push_id;
  logic [KIND_BITS-1:0] push_kind;
  logic [CW-1:0]        applied_m1;
  logic [AW-1:0]        rd_addr;

  assign full       = (applied_q == CW'(LOG_DEPTH));
  assign id_ok      = (id_q != '0) && ({1'b0, id_q} < next_q);
  assign hit        = (rd_id_q == id_q);
  assign applied_m1 = applied_q - 1'b1;

  assign sts_o.is_query  = (op_q == OP_QUERY);
  assign sts_o.needs_mem = ((op_q == OP_UNDO) && (applied_q != '0)) ||
                           ((op_q == OP_REDO) && (applied_q < top_q)) ||
                           ((op_q == OP_QUERY) && (applied_q != '0));
  assign sts_o.scan_stop = hit || (p_q == '0);

  // read address: top of the applied entries at start (the entry just above them for redo), then one down per step
  always_comb begin
    rd_en   = cmd_i.start_rd | cmd_i.scan_step;
    rd_addr = p_q - 1'b1;
    if (cmd_i.start_rd) begin
      rd_addr = (op_q == OP_REDO) ? applied_q[AW-1:0] : applied_m1[AW-1:0];
    end
    p_d = rd_en ? rd_addr : p_q;
  end

  always_comb begin
    applied_d      = applied_q;
    top_d          = top_q;
    next_d         = next_q;
    vt_d           = vt_q;
    start_d        = start_q;
    res_status_d   = res_status_q;
    res_assigned_d = res_assigned_q;
    res_exists_d   = res_exists_q;
    push           = 1'b0;
    push_id        = id_q;
    push_kind      = KIND_ADD;

    if (cfg_we_i) begin
      start_d = cfg_wdata_i;
      next_d  = {1'b0, cfg_wdata_i};
    end

    if (cmd_i.exec) begin
      res_status_d   = ST_OK;
      res_assigned_d = '0;
      res_exists_d   = 1'b0;
      case (op_q)
        OP_ADD: begin
          if (full || next_q[ID_BITS]) begin
            res_status_d = ST_FULL;
          end else begin
            push           = 1'b1;
            push_id        = next_q[ID_BITS-1:0];
            push_kind      = KIND_ADD;
            res_assigned_d = next_q[ID_BITS-1:0];
            next_d         = next_q + 1'b1;
            vt_d           = vt_q + 1'b1;
          end
        end
        OP_DEL, OP_UPD: begin
          if (!id_ok) begin
            res_status_d = ST_INVALID;
          end else if (full) begin
            res_status_d = ST_FULL;
          end else begin
            push = 1'b1;
            if (op_q == OP_DEL) begin
              push_kind = KIND_DEL;
              vt_d      = vt_q - 1'b1;
            end else begin
              push_kind = KIND_UPD;
            end
          end
        end
        OP_UNDO, OP_REDO: begin
          res_status_d = ST_EMPTY;
        end
        default: begin
          res_status_d = ST_OK;
        end
      endcase
      if (push) begin
        // a new edit drops everything above the cursor
        applied_d = applied_q + 1'b1;
        top_d     = applied_q + 1'b1;
      end
    end

    if (cmd_i.apply_ur) begin
      res_status_d   = ST_OK;
      res_assigned_d = '0;
      res_exists_d   = 1'b0;
      if (op_q == OP_UNDO) begin
        applied_d = applied_m1;
        if (rd_kind_q == KIND_ADD) begin
          vt_d = vt_q - 1'b1;
        end else if (rd_kind_q == KIND_DEL) begin
          vt_d = vt_q + 1'b1;
        end
      end else begin
        applied_d = applied_q + 1'b1;
        if (rd_kind_q == KIND_ADD) begin
          vt_d = vt_q + 1'b1;
        end else if (rd_kind_q == KIND_DEL) begin
          vt_d = vt_q - 1'b1;
        end
      end
    end

    if (cmd_i.scan_end) begin
      res_status_d   = ST_OK;
      res_assigned_d = '0;
      res_exists_d   = hit && (rd_kind_q != KIND_DEL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q <= '0;
      top_q     <= '0;
      next_q    <= (ID_BITS + 1)'(1);
      vt_q      <= '0;
      start_q   <= ID_BITS'(1);
    end else begin
      applied_q <= applied_d;
      top_q     <= top_d;
      next_q    <= next_d;
      vt_q      <= vt_d;
      start_q   <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_op_i;
      id_q <= in_id_i;
    end
    p_q            <= p_d;
    res_status_q   <= res_status_d;
    res_assigned_q <= res_assigned_d;
    res_exists_q   <= res_exists_d;
  end

  // log memory: one write port at the cursor, one registered read port
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[applied_q[AW-1:0]] <= {push_id, push_kind};
    end
    if (rd_en) begin
      {rd_id_q, rd_kind_q} <= mem_q[rd_addr];
    end
  end

  assign start_id_o    = start_q;
  assign status_o      = res_status_q;
  assign assigned_o    = res_assigned_q;
  assign exists_o      = res_exists_q;
  assign valid_count_o = vt_q;
  assign can_undo_o    = (applied_q != '0);
  assign can_redo_o    = (applied_q < top_q);

endmodule

// ----- src/edit_log_undo_redo_core.sv -----
// Edit log with undo/redo. One item is worked at a time: after an input beat
// is taken, add, delete, update and an empty undo/redo or query give their
// result beat from S_EXEC through S_OUT, a real undo/redo also passes S_READ,
// and a query walks n log entries in S_SCAN (n is 1 up to LOG_DEPTH) down
// from the cursor to the newest one with that id, or to the bottom; the
// log memory's single read port sets that one-entry-per-cycle walk. The next
// input beat is taken the cycle after the result beat leaves. Log entries
// above the top are never read, so the memory needs no clearing after reset.
// start_id sits at byte address 0 and also reloads the next issued id.
// depends on elur_pkg, elur_ctrl and elur_dp
module edit_log_undo_redo_core #(
  parameter int LOG_DEPTH = elur_pkg::LOG_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // op [2:0], item_id [18:3], zero pad above
  input  logic [elur_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // status [1:0], assigned_id [17:2], exists [18], valid_count [35:19],
  // can_undo [36], can_redo [37], zero pad above
  output logic [elur_pkg::OUT_W-1:0]  m_axis_tdata_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [elur_pkg::CFG_AW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);
  import elur_pkg::*;

  cmd_t                        cmd;
  sts_t                        sts;
  logic                        cfg_we;
  logic [ID_BITS-1:0]          start_id;
  logic [ST_BITS-1:0]          status;
  logic [ID_BITS-1:0]          assigned_id;
  logic                        exists;
  logic signed [CNT_BITS-1:0]  valid_count;
  logic                        can_undo, can_redo;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i == REG_START_ID);
  assign prdata_o = (paddr_i == REG_START_ID) ? {{(32-ID_BITS){1'b0}}, start_id} : '0;

  elur_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  elur_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata_i[ID_BITS-1:0]),
    .start_id_o    (start_id),
    .in_op_i       (s_axis_tdata_i[OP_BITS-1:0]),
    .in_id_i       (s_axis_tdata_i[OP_BITS +: ID_BITS]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status),
    .assigned_o    (assigned_id),
    .exists_o      (exists),
    .valid_count_o (valid_count),
    .can_undo_o    (can_undo),
    .can_redo_o    (can_redo)
  );

  assign m_axis_tdata_o = {{(OUT_W-OUT_RAW){1'b0}}, can_redo, can_undo, valid_count,
                           exists, assigned_id, status};

  // one item in flight: never ready for input while a result beat is shown
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  // an accepted beat blocks further input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("not busy after accept");

  // a failed step issues no id and answers no query
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status != ST_OK)) |-> (assigned_id == '0) && !exists)
    else $error("failed step carries payload");

endmodule

// ----- tb/tb_edit_log_undo_redo_core.sv -----
// self-checking testbench for edit_log_undo_redo_core: a directed run, then random bursts
// checked beat by beat against a predictor of the edit log, undo/redo cursor and valid count
// depends on elur_pkg and the core rtl
module tb_edit_log_undo_redo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import elur_pkg::*;

  localparam int LOG_CAP = LOG_DEPTH_DEF;
  localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;
  localparam logic [ID_BITS:0]   ID_CEIL    = {1'b0, {ID_BITS{1'b1}}};

  typedef enum logic [1:0] {PICK_AS_IS, PICK_ISSUED, PICK_LOGGED} id_pick_e;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [ID_BITS-1:0] id;
    id_pick_e           pick;
  } edit_req_t;

  typedef struct packed {
    logic [ST_BITS-1:0]  status;
    logic [ID_BITS-1:0]  assigned;
    logic                exists;
    logic [CNT_BITS-1:0] count;
    logic                can_undo;
    logic                can_redo;
  } reply_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [IN_W-1:0]    s_data  = '0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [OUT_W-1:0]   m_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [CFG_AW-1:0]  paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  edit_log_undo_redo_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  // predictor state
  logic [ID_BITS-1:0]   log_ids   [LOG_CAP];
  logic [KIND_BITS-1:0] log_kinds [LOG_CAP];
  int                   applied_n  = 0;
  int                   top_n      = 0;
  logic [ID_BITS:0]     next_issue = 17'd1;
  logic [CNT_BITS-1:0]  live_count = '0;

  edit_req_t          pending_edits[$];
  reply_t             due_replies[$];
  int                 queued_cnt = 0;
  int                 taken_cnt  = 0;
  int                 mismatches = 0;
  bit                 in_taken   = 1'b0;
  logic [OP_BITS-1:0] cur_op     = '0;
  logic [ID_BITS-1:0] cur_id     = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic logic [ID_BITS-1:0] rand_id();
    return ID_BITS'($urandom_range({ID_BITS{1'b1}}));
  endfunction

  function automatic logic [OP_BITS-1:0] rand_op();
    return OP_BITS'($urandom_range(7));
  endfunction

  function automatic void log_push(logic [ID_BITS-1:0] id, logic [KIND_BITS-1:0] kind);
    log_ids[applied_n]   = id;
    log_kinds[applied_n] = kind;
    applied_n++;
    top_n = applied_n;
  endfunction

  function automatic reply_t predict_edit_reply(logic [OP_BITS-1:0] op,
                                                logic [ID_BITS-1:0] id);
    reply_t r;
    logic   id_ok;
    int     i;
    r     = '0;
    id_ok = (id != '0) && ({1'b0, id} < next_issue);
    case (op)
      OP_ADD: begin
        if (applied_n >= LOG_CAP || next_issue > ID_CEIL) begin
          r.status = ST_FULL;
        end else begin
          r.assigned = next_issue[ID_BITS-1:0];
          log_push(next_issue[ID_BITS-1:0], KIND_ADD);
          next_issue++;
          live_count++;
        end
      end
      OP_DEL, OP_UPD: begin
        if (!id_ok) begin
          r.status = ST_INVALID;
        end else if (applied_n >= LOG_CAP) begin
          r.status = ST_FULL;
        end else if (op == OP_DEL) begin
          log_push(id, KIND_DEL);
          live_count--;
        end else begin
          log_push(id, KIND_UPD);
        end
      end
      OP_UNDO: begin
        if (applied_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          applied_n--;
          if (log_kinds[applied_n] == KIND_ADD) live_count--;
          else if (log_kinds[applied_n] == KIND_DEL) live_count++;
        end
      end
      OP_REDO: begin
        if (applied_n >= top_n) begin
          r.status = ST_EMPTY;
        end else begin
          if (log_kinds[applied_n] == KIND_ADD) live_count++;
          else if (log_kinds[applied_n] == KIND_DEL) live_count--;
          applied_n++;
        end
      end
      OP_QUERY: begin
        // newest applied entry for the id decides
        for (i = applied_n - 1; i >= 0; i--) begin
          if (log_ids[i] == id) begin
            r.exists = (log_kinds[i] != KIND_DEL);
            break;
          end
        end
      end
      default: ;
    endcase
    r.count    = live_count;
    r.can_undo = (applied_n > 0);
    r.can_redo = (applied_n < top_n);
    return r;
  endfunction

  // input side: pick the id from the live log state when the beat is loaded
  always @(negedge clk_i) begin
    edit_req_t          req;
    logic [ID_BITS-1:0] id;
    int                 lo;
    bit                 calm;
    calm = (taken_cnt >= 400) && (taken_cnt < 520);
    m_ready <= rst_ni && (calm || $urandom_range(99) >= 25);
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_edits.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        req = pending_edits.pop_front();
        id  = req.id;
        case (req.pick)
          PICK_ISSUED: begin
            if (next_issue > 1) begin
              lo = (next_issue > 9 && $urandom_range(1) == 1) ? int'(next_issue) - 8 : 1;
              id = ID_BITS'($urandom_range(int'(next_issue) - 1, lo));
            end
          end
          PICK_LOGGED: begin
            // entries above the cursor too, so undone edits get queried
            if (top_n > 0) id = log_ids[$urandom_range(top_n - 1, 0)];
          end
          default: ;
        endcase
        cur_op = req.op;
        cur_id = id;
        s_data  <= {{(IN_W-IN_RAW){1'b0}}, id, req.op};
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // accepted input beats feed the predictor, output beats are checked against it
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        due_replies.insert(due_replies.size(), predict_edit_reply(cur_op, cur_id));
        taken_cnt++;
        in_taken = 1'b1;
      end
      if (m_valid && m_ready) begin
        if (due_replies.size() == 0) begin
          report_mismatch($sformatf("result beat %0h with none pending", m_data));
        end else begin
          want = due_replies.pop_front();
          check_field("status", 32'(m_data[1:0]), 32'(want.status));
          check_field("assigned_id", 32'(m_data[17:2]), 32'(want.assigned));
          check_field("exists", 32'(m_data[18]), 32'(want.exists));
          check_field("valid_count", 32'(m_data[35:19]), 32'(want.count));
          check_field("can_undo", 32'(m_data[36]), 32'(want.can_undo));
          check_field("can_redo", 32'(m_data[37]), 32'(want.can_redo));
        end
      end
    end
  end

  task automatic queue_edit(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id,
                            id_pick_e pick = PICK_AS_IS);
    edit_req_t req;
    req.op   = op;
    req.id   = id;
    req.pick = pick;
    pending_edits.insert(pending_edits.size(), req);
    queued_cnt++;
  endtask

  // stray ids now and then, otherwise issued ones
  task automatic queue_edit_beat();
    int r;
    id_pick_e pick;
    r    = $urandom_range(99);
    pick = ($urandom_range(99) < 8) ? PICK_AS_IS : PICK_ISSUED;
    if (r < 50) queue_edit(OP_ADD, rand_id());
    else if (r < 75) queue_edit(OP_UPD, rand_id(), pick);
    else queue_edit(OP_DEL, rand_id(), pick);
  endtask

  task automatic queue_random_mix(int n);
    int left;
    int len;
    int kind;
    int r;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(9);
      len  = (kind == 8) ? $urandom_range(8, 4) : $urandom_range(30, 5);
      if (len > left) len = left;
      left -= len;
      repeat (len) begin
        r = $urandom_range(99);
        case (kind)
          0, 1, 2, 3: begin
            if (r < 60) queue_edit_beat();
            else if (r < 73) queue_edit(OP_UNDO, rand_id());
            else if (r < 85) queue_edit(OP_REDO, rand_id());
            else if (r < 97) queue_edit(OP_QUERY, rand_id(),
                                        (r < 93) ? PICK_LOGGED : PICK_ISSUED);
            else queue_edit(rand_op(), rand_id());
          end
          4, 5: queue_edit_beat();
          6: begin
            if (r < 90) queue_edit(OP_UNDO, rand_id());
            else queue_edit(OP_QUERY, rand_id(), PICK_LOGGED);
          end
          7: begin
            if (r < 90) queue_edit(OP_REDO, rand_id());
            else queue_edit(OP_QUERY, rand_id(), PICK_LOGGED);
          end
          8: queue_edit(rand_op(), rand_id());
          default: begin
            if (r < 75) queue_edit(OP_QUERY, rand_id(), PICK_LOGGED);
            else if (r < 90) queue_edit(OP_QUERY, rand_id(), PICK_ISSUED);
            else queue_edit(OP_QUERY, rand_id());
          end
        endcase
      end
    end
  endtask

  task automatic drain();
    while (taken_cnt != queued_cnt || due_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_start_id(logic [ID_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_START_ID;
    pwdata  <= {{(32-ID_BITS){1'b0}}, value};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    next_issue = {1'b0, value};
    // read back right after the write
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("start_id readback", prdata, {{(32-ID_BITS){1'b0}}, value});
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // empty log, invalid ids, repeated delete, count below zero, spare op codes
    queue_edit(OP_UNDO, 16'h0000);
    queue_edit(OP_REDO, 16'hFFFF);
    queue_edit(OP_QUERY, 16'h0000);
    queue_edit(OP_DEL, 16'h0000);
    queue_edit(OP_UPD, 16'h0001);
    queue_edit(OP_ADD, 16'hFFFF);
    queue_edit(OP_ADD, 16'h0000);
    queue_edit(OP_UPD, 16'h0002);
    queue_edit(OP_DEL, 16'h0001);
    queue_edit(OP_DEL, 16'h0001);
    queue_edit(OP_DEL, 16'h0002);
    queue_edit(OP_QUERY, 16'h0001);
    queue_edit(OP_QUERY, 16'h0002);
    queue_edit(OP_QUERY, 16'h0003);
    queue_edit(OP_UNDO, 16'h0000);
    queue_edit(OP_QUERY, 16'h0002);
    queue_edit(OP_REDO, 16'h0000);
    queue_edit(OP_REDO, 16'h0000);
    queue_edit(OP_SPARE_A, 16'hFFFF);
    queue_edit(OP_SPARE_B, 16'h0000);
    queue_edit(OP_DEL, 16'hFFFF);
    queue_edit(OP_UPD, 16'h0003);
    queue_edit(OP_QUERY, 16'hFFFF);
    drain();

    // top id: one add gets it, the next finds the ids used up
    write_start_id(16'hFFFF);
    queue_edit(OP_ADD, 16'h0000);
    queue_edit(OP_ADD, 16'h0000);
    queue_edit(OP_QUERY, 16'hFFFF);
    queue_edit(OP_DEL, 16'hFFFF);
    drain();

    write_start_id(ID_BITS'($urandom_range(60000, 2)));
    queue_random_mix(300);
    drain();

    // long edit run drives the log into its full state
    write_start_id(16'd1);
    repeat (320) queue_edit_beat();
    queue_random_mix(100);
    drain();

    write_start_id(ID_BITS'(16'hFFFF - $urandom_range(40, 10)));
    queue_random_mix(200);
    drain();

    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
